@@ design/acss_pkg.sv @@
package acss_pkg;

    localparam int DATA_W      = 16;
    localparam int CHAN_W      = 2;
    localparam int FS_W        = 14;
    localparam int ABS_W       = DATA_W + 1;
    localparam int PROD_W      = ABS_W + FS_W;
    localparam int MAG_W       = 29;
    localparam int TDATA_IN_W  = 24;
    localparam int TDATA_OUT_W = 32;
    localparam int PADDR_W     = 3;

    localparam logic [1:0] CMD_CONV  = 2'd0;
    localparam logic [1:0] CMD_WDOG  = 2'd1;
    localparam logic [1:0] CMD_CFG   = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_BAD_CHAN  = 2'd1;
    localparam logic [1:0] STAT_NOT_VALID = 2'd2;

    localparam logic REG_FULL_SCALE  = 1'b0;
    localparam logic REG_DIS_READING = 1'b1;

    localparam logic [FS_W-1:0]          FS_RESET      = 14'd4096;
    localparam logic signed [DATA_W-1:0] READING_RESET = 16'sh8000;

    typedef struct packed {
        logic [1:0]              cmd;
        logic [CHAN_W-1:0]       channel;
        logic                    enable;
        logic [DATA_W-1:0]       conv_word;
        logic                    in_millivolts;
    } item_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [DATA_W-1:0] reading;
        logic                    select_valid;
        logic [CHAN_W-1:0]       select_channel;
        logic                    notify_valid;
        logic [CHAN_W-1:0]       notify_channel;
        logic                    force_read;
    } result_t;

    typedef struct packed {
        result_t                 res;
        logic                    use_mv;
        logic                    neg;
        logic [MAG_W-1:0]        mag;
    } scale_t;

endpackage

@@ design/adc_channel_scan_sequencer_unit.sv @@
// Throughput: one transaction per cycle; the input, sequencer, divide and output
// registers form a 4-stage pipeline that stalls as one while a result waits on m_tready.
// Reset: masks, flags, current channel and watchdog cleared, all readings set to
// -32768, full_scale_mv to 4096, disabled_reading to -32768, pipeline emptied.
module adc_channel_scan_sequencer_unit #(
    parameter int NUM_CHANNELS  = 4,
    parameter int CODE_COUNT    = 2048,
    parameter int RESERVED_BITS = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // channel[1:0], enable[2], conv_word[18:3], in_millivolts[19], zero pad
    input  logic [acss_pkg::TDATA_IN_W-1:0]     s_tdata,
    // cmd[1:0]
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status[1:0], reading[17:2], select_valid[18], select_channel[20:19],
    // notify_valid[21], notify_channel[23:22], force_read[24], zero pad
    output logic [acss_pkg::TDATA_OUT_W-1:0]    m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [acss_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    acss_pkg::item_t                    item;
    acss_pkg::scale_t                   stage;
    acss_pkg::result_t                  result;
    logic                               stage_valid;
    logic                               adv;
    logic [acss_pkg::FS_W-1:0]          full_scale;
    logic signed [acss_pkg::DATA_W-1:0] disabled_reading;

    assign item.cmd           = s_tuser;
    assign item.channel       = s_tdata[1:0];
    assign item.enable        = s_tdata[2];
    assign item.conv_word     = s_tdata[18:3];
    assign item.in_millivolts = s_tdata[19];

    assign s_tready = adv;

    acss_cfg u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .full_scale       (full_scale),
        .disabled_reading (disabled_reading)
    );

    acss_seq #(
        .NUM_CHANNELS  (NUM_CHANNELS),
        .RESERVED_BITS (RESERVED_BITS)
    ) u_seq (
        .clk              (clk),
        .rst_n            (rst_n),
        .adv              (adv),
        .item_valid       (s_tvalid),
        .item             (item),
        .full_scale       (full_scale),
        .disabled_reading (disabled_reading),
        .stage_valid      (stage_valid),
        .stage            (stage)
    );

    acss_scale #(
        .CODE_COUNT (CODE_COUNT)
    ) u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .stage       (stage),
        .out_ready   (m_tready),
        .adv         (adv),
        .out_valid   (m_tvalid),
        .result      (result)
    );

    assign m_tdata = {7'd0,
                      result.force_read,
                      result.notify_channel,
                      result.notify_valid,
                      result.select_channel,
                      result.select_valid,
                      result.reading,
                      result.status};

endmodule

@@ design/acss_cfg.sv @@
module acss_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [acss_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output logic [acss_pkg::FS_W-1:0]         full_scale,
    output logic signed [acss_pkg::DATA_W-1:0] disabled_reading
);

    logic [acss_pkg::FS_W-1:0]          fs_reg;
    logic signed [acss_pkg::DATA_W-1:0] dis_reg;
    logic                               wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg  <= acss_pkg::FS_RESET;
            dis_reg <= acss_pkg::READING_RESET;
        end
        else if (wr)
        begin
            unique case (paddr[2])
                acss_pkg::REG_FULL_SCALE:  fs_reg  <= pwdata[acss_pkg::FS_W-1:0];
                acss_pkg::REG_DIS_READING: dis_reg <= pwdata[acss_pkg::DATA_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            acss_pkg::REG_FULL_SCALE:  prdata = 32'(fs_reg);
            acss_pkg::REG_DIS_READING: prdata = {16'd0, dis_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    assign full_scale       = fs_reg;
    assign disabled_reading = dis_reg;

endmodule

@@ design/acss_seq.sv @@
module acss_seq #(
    parameter int NUM_CHANNELS  = 4,
    parameter int RESERVED_BITS = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               adv,
    input  logic                               item_valid,
    input  acss_pkg::item_t                    item,
    input  logic [acss_pkg::FS_W-1:0]          full_scale,
    input  logic signed [acss_pkg::DATA_W-1:0] disabled_reading,
    output logic                               stage_valid,
    output acss_pkg::scale_t                   stage
);

    localparam int CHW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CODE_W = acss_pkg::DATA_W - RESERVED_BITS;

    logic                               in_vld_reg;
    acss_pkg::item_t                    in_reg;
    logic                               s1_vld_reg;
    acss_pkg::scale_t                   s1_reg;
    acss_pkg::scale_t                   s1_next;

    logic [NUM_CHANNELS-1:0]            en_reg, en_next;
    logic [NUM_CHANNELS-1:0]            pend_reg, pend_next;
    logic [CHW-1:0]                     cur_reg, cur_next;
    logic                               ok_reg, ok_next;
    logic                               kicked_reg, kicked_next;
    logic                               run_reg, run_next;
    logic signed [acss_pkg::DATA_W-1:0] rd_reg [NUM_CHANNELS];

    logic                               go;
    logic                               rd_we;
    logic [CHW-1:0]                     rd_idx;
    logic signed [acss_pkg::DATA_W-1:0] rd_wdata;
    logic signed [CODE_W-1:0]           conv_code;
    logic signed [acss_pkg::DATA_W-1:0] conv_val;
    logic [CHW-1:0]                     ch_idx;
    logic                               ch_ok;
    logic [NUM_CHANNELS-1:0]            cur_onehot;
    logic [NUM_CHANNELS-1:0]            pend_clr;
    logic [NUM_CHANNELS-1:0]            pend_rot;
    logic [CHW-1:0]                     low_idx;
    logic [NUM_CHANNELS-1:0]            en_cfg;
    logic signed [acss_pkg::DATA_W-1:0] rd_sel;
    logic [acss_pkg::ABS_W-1:0]         rd_abs;
    logic [acss_pkg::PROD_W-1:0]        prod;

    assign go         = adv && in_vld_reg;
    assign conv_code  = in_reg.conv_word[acss_pkg::DATA_W-1:RESERVED_BITS];
    assign conv_val   = acss_pkg::DATA_W'(conv_code);
    assign ch_idx     = CHW'(in_reg.channel);
    assign ch_ok      = 32'(in_reg.channel) < NUM_CHANNELS;
    assign cur_onehot = NUM_CHANNELS'(1) << cur_reg;
    assign pend_clr   = pend_reg & ~cur_onehot;
    assign pend_rot   = (pend_clr == '0) ? en_reg : pend_clr;

    always_comb
    begin
        low_idx = '0;
        for (int i = NUM_CHANNELS - 1; i >= 0; i--)
        begin
            if (pend_rot[i])
            begin
                low_idx = CHW'(i);
            end
        end
    end

    always_comb
    begin
        en_cfg = en_reg;
        en_cfg[ch_idx] = in_reg.enable;
    end

    assign rd_sel = rd_reg[ch_idx];
    assign rd_abs = rd_sel[acss_pkg::DATA_W-1]
                    ? (acss_pkg::ABS_W'(0) - acss_pkg::ABS_W'(rd_sel))
                    : acss_pkg::ABS_W'(rd_sel);
    assign prod   = acss_pkg::PROD_W'(rd_abs) * acss_pkg::PROD_W'(full_scale);

    always_comb
    begin
        en_next     = en_reg;
        pend_next   = pend_reg;
        cur_next    = cur_reg;
        ok_next     = ok_reg;
        kicked_next = kicked_reg;
        run_next    = run_reg;
        rd_we       = 1'b0;
        rd_idx      = cur_reg;
        rd_wdata    = conv_val;
        s1_next     = '0;
        s1_next.mag = prod[acss_pkg::MAG_W-1:0];
        s1_next.neg = rd_sel[acss_pkg::DATA_W-1];

        unique case (in_reg.cmd)
            acss_pkg::CMD_CONV:
            begin
                if (en_reg != '0)
                begin
                    if (en_reg[cur_reg])
                    begin
                        rd_we   = 1'b1;
                        ok_next = 1'b1;
                        s1_next.res.notify_valid   = 1'b1;
                        s1_next.res.notify_channel = acss_pkg::CHAN_W'(cur_reg);
                    end
                    pend_next   = pend_rot;
                    cur_next    = low_idx;
                    kicked_next = 1'b1;
                    s1_next.res.select_valid   = 1'b1;
                    s1_next.res.select_channel = acss_pkg::CHAN_W'(low_idx);
                end
            end
            acss_pkg::CMD_WDOG:
            begin
                if (run_reg)
                begin
                    if (!kicked_reg)
                    begin
                        ok_next = 1'b0;
                        s1_next.res.force_read = 1'b1;
                    end
                    kicked_next = 1'b0;
                end
            end
            acss_pkg::CMD_CFG:
            begin
                if (ch_ok)
                begin
                    en_next   = en_cfg;
                    pend_next = en_cfg;
                    if (en_reg == '0 && in_reg.enable)
                    begin
                        cur_next = ch_idx;
                        s1_next.res.select_valid   = 1'b1;
                        s1_next.res.select_channel = in_reg.channel;
                    end
                    else if (!in_reg.enable)
                    begin
                        rd_we    = 1'b1;
                        rd_idx   = ch_idx;
                        rd_wdata = disabled_reading;
                    end
                    if (en_cfg != '0 && !run_reg)
                    begin
                        kicked_next = 1'b0;
                        run_next    = 1'b1;
                    end
                    else if (en_cfg == '0)
                    begin
                        run_next = 1'b0;
                    end
                end
            end
            acss_pkg::CMD_READ:
            begin
                if (!ch_ok)
                begin
                    s1_next.res.status = acss_pkg::STAT_BAD_CHAN;
                end
                else if (!en_reg[ch_idx])
                begin
                    s1_next.res.status = acss_pkg::STAT_BAD_CHAN;
                end
                else if (!ok_reg)
                begin
                    s1_next.res.status = acss_pkg::STAT_NOT_VALID;
                end
                else if (!in_reg.in_millivolts)
                begin
                    s1_next.res.reading = rd_sel;
                end
                else
                begin
                    s1_next.use_mv = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            en_reg     <= '0;
            pend_reg   <= '0;
            cur_reg    <= '0;
            ok_reg     <= 1'b0;
            kicked_reg <= 1'b0;
            run_reg    <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                rd_reg[i] <= acss_pkg::READING_RESET;
            end
        end
        else
        begin
            if (adv)
            begin
                in_vld_reg <= item_valid;
                s1_vld_reg <= in_vld_reg;
            end
            if (go)
            begin
                en_reg     <= en_next;
                pend_reg   <= pend_next;
                cur_reg    <= cur_next;
                ok_reg     <= ok_next;
                kicked_reg <= kicked_next;
                run_reg    <= run_next;
                if (rd_we)
                begin
                    rd_reg[rd_idx] <= rd_wdata;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && item_valid)
        begin
            in_reg <= item;
        end
        if (go)
        begin
            s1_reg <= s1_next;
        end
    end

    assign stage_valid = s1_vld_reg;
    assign stage       = s1_reg;

    a_pend_in_en: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg & ~en_reg) == '0)
        else $error("pending channel not enabled");

    a_wdog_run: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg == (en_reg != '0))
        else $error("watchdog run flag out of step with enable mask");

    a_notify_sel: assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg && s1_reg.res.notify_valid |-> s1_reg.res.select_valid)
        else $error("stored reading without channel rotation");

endmodule

@@ design/acss_scale.sv @@
module acss_scale #(
    parameter int CODE_COUNT = 2048
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 stage_valid,
    input  acss_pkg::scale_t     stage,
    input  logic                 out_ready,
    output logic                 adv,
    output logic                 out_valid,
    output acss_pkg::result_t    result
);

    localparam int LOG2C   = $clog2(CODE_COUNT);
    localparam int SHIFT   = acss_pkg::MAG_W + LOG2C;
    localparam int RECIP_W = acss_pkg::MAG_W + 1;
    localparam int QPROD_W = acss_pkg::MAG_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(CODE_COUNT) - 64'd1) / 64'(CODE_COUNT);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam logic [acss_pkg::MAG_W-1:0] POS_MAX = acss_pkg::MAG_W'(32767);
    localparam logic [acss_pkg::MAG_W-1:0] NEG_MAX = acss_pkg::MAG_W'(32768);

    logic                              s2_vld_reg;
    acss_pkg::scale_t                  s2_reg;
    acss_pkg::scale_t                  s2_next;
    logic                              out_vld_reg;
    acss_pkg::result_t                 out_reg;
    logic [QPROD_W-1:0]                qprod;
    logic [acss_pkg::MAG_W-1:0]        quot;
    logic signed [acss_pkg::DATA_W-1:0] mv_val;
    acss_pkg::result_t                 out_next;

    assign adv   = !out_vld_reg || out_ready;
    assign qprod = QPROD_W'(stage.mag) * QPROD_W'(RECIP);
    assign quot  = acss_pkg::MAG_W'(qprod >> SHIFT);

    always_comb
    begin
        s2_next     = stage;
        s2_next.mag = quot;
    end

    always_comb
    begin
        if (!s2_reg.neg)
        begin
            mv_val = (s2_reg.mag > POS_MAX) ? 16'sh7FFF
                                            : acss_pkg::DATA_W'(s2_reg.mag);
        end
        else
        begin
            mv_val = (s2_reg.mag > NEG_MAX)
                     ? 16'sh8000
                     : acss_pkg::DATA_W'(acss_pkg::MAG_W'(0) - s2_reg.mag);
        end
        out_next = s2_reg.res;
        if (s2_reg.use_mv)
        begin
            out_next.reading = mv_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_vld_reg  <= stage_valid;
            out_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && stage_valid)
        begin
            s2_reg <= s2_next;
        end
        if (adv && s2_vld_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign result    = out_reg;

endmodule

@@ verif/tb_top.sv @@
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CODES = 2048;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [acss_pkg::TDATA_IN_W-1:0]  s_tdata = '0;
    logic [1:0]                       s_tuser = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [acss_pkg::TDATA_OUT_W-1:0] m_tdata;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [acss_pkg::PADDR_W-1:0]     paddr = '0;
    logic [31:0]                      pwdata = '0;
    logic [31:0]                      prdata;
    logic                             pready;

    adc_channel_scan_sequencer_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // scan state mirror
    logic [3:0]                         en_mask;
    logic [3:0]                         pend_mask;
    logic [1:0]                         cur_ch;
    logic signed [acss_pkg::DATA_W-1:0] chan_reading [4];
    bit                                 readings_ok;
    bit                                 wd_kicked;
    bit                                 wd_running;
    logic [acss_pkg::FS_W-1:0]          fs_mv;
    logic signed [acss_pkg::DATA_W-1:0] dis_val;

    acss_pkg::result_t pending_results [$];

    bit src_idle = 1'b1;
    bit sink_idle = 1'b1;
    int stall_left = 0;
    int errors = 0;
    int cnt_items = 0;
    int cnt_results = 0;
    int cnt_notify = 0;
    int cnt_forced = 0;
    int cnt_mv = 0;
    int cnt_settings = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic acss_pkg::result_t scan_step(acss_pkg::item_t it);
        acss_pkg::result_t r;
        logic [11:0] code;
        logic [3:0]  old;
        longint      prod;
        longint      quo;
        r = '0;
        r.status = acss_pkg::STAT_OK;
        case (it.cmd)
            acss_pkg::CMD_CONV:
                if (en_mask != 4'd0)
                begin
                    if (en_mask[cur_ch])
                    begin
                        code = it.conv_word[15:4];
                        chan_reading[cur_ch] = {{4{code[11]}}, code};
                        readings_ok = 1'b1;
                        r.notify_valid = 1'b1;
                        r.notify_channel = cur_ch;
                        cnt_notify++;
                    end
                    pend_mask[cur_ch] = 1'b0;
                    if (pend_mask == 4'd0)
                        pend_mask = en_mask;
                    for (int i = 3; i >= 0; i--)
                        if (pend_mask[i])
                            cur_ch = 2'(i);
                    r.select_valid = 1'b1;
                    r.select_channel = cur_ch;
                    wd_kicked = 1'b1;
                end
            acss_pkg::CMD_WDOG:
                if (wd_running)
                begin
                    if (!wd_kicked)
                    begin
                        readings_ok = 1'b0;
                        r.force_read = 1'b1;
                        cnt_forced++;
                    end
                    wd_kicked = 1'b0;
                end
            acss_pkg::CMD_CFG:
            begin
                old = en_mask;
                en_mask[it.channel] = it.enable;
                pend_mask = en_mask;
                if (old == 4'd0 && it.enable)
                begin
                    cur_ch = it.channel;
                    r.select_valid = 1'b1;
                    r.select_channel = it.channel;
                end
                else if (!it.enable)
                    chan_reading[it.channel] = dis_val;
                if (en_mask != 4'd0 && !wd_running)
                begin
                    wd_kicked = 1'b0;
                    wd_running = 1'b1;
                end
                else if (en_mask == 4'd0)
                    wd_running = 1'b0;
            end
            default:
                if (!en_mask[it.channel])
                    r.status = acss_pkg::STAT_BAD_CHAN;
                else if (!readings_ok)
                    r.status = acss_pkg::STAT_NOT_VALID;
                else if (!it.in_millivolts)
                    r.reading = chan_reading[it.channel];
                else
                begin
                    prod = longint'(chan_reading[it.channel]) * longint'(fs_mv);
                    quo = prod / CODES;
                    if (quo > 32767)
                        quo = 32767;
                    else if (quo < -32768)
                        quo = -32768;
                    r.reading = quo[15:0];
                    cnt_mv++;
                end
        endcase
        return r;
    endfunction

    // input monitor: predict on every accepted transaction
    always @(posedge clk)
    begin
        acss_pkg::item_t it;
        if (rst_n && s_tvalid && s_tready)
        begin
            it.cmd = s_tuser;
            it.channel = s_tdata[1:0];
            it.enable = s_tdata[2];
            it.conv_word = s_tdata[18:3];
            it.in_millivolts = s_tdata[19];
            pending_results.push_back(scan_step(it));
            cnt_items++;
        end
    end

    task automatic check_field(string name, longint e, longint a);
        if (e != a)
        begin
            $error("%s: expected %0d, got %0d", name, e, a);
            errors++;
        end
    endtask

    // output checker
    always @(posedge clk)
    begin
        acss_pkg::result_t want;
        acss_pkg::result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status = m_tdata[1:0];
            got.reading = m_tdata[17:2];
            got.select_valid = m_tdata[18];
            got.select_channel = m_tdata[20:19];
            got.notify_valid = m_tdata[21];
            got.notify_channel = m_tdata[23:22];
            got.force_read = m_tdata[24];
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction: %h", m_tdata);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", want.status, got.status);
                check_field("reading", want.reading, got.reading);
                check_field("select_valid", want.select_valid, got.select_valid);
                check_field("select_channel", want.select_channel, got.select_channel);
                check_field("notify_valid", want.notify_valid, got.notify_valid);
                check_field("notify_channel", want.notify_channel, got.notify_channel);
                check_field("force_read", want.force_read, got.force_read);
                cnt_results++;
            end
        end
    end

    // result sink with random stalls and requested long hold-off
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= !(sink_idle && $urandom_range(99) < 15);
    end

    task automatic send_item(acss_pkg::item_t it);
        @(negedge clk);
        while (src_idle && $urandom_range(99) < 15)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.cmd;
        s_tdata <= {4'd0, it.in_millivolts, it.conv_word, it.enable, it.channel};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        stop_sending();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == acss_pkg::REG_FULL_SCALE)
            fs_mv = val[acss_pkg::FS_W-1:0];
        else
            dis_val = val[acss_pkg::DATA_W-1:0];
    endtask

    task automatic set_regs(logic [31:0] fs, logic signed [15:0] dis);
        wait_drained();
        write_reg(acss_pkg::REG_FULL_SCALE, fs);
        write_reg(acss_pkg::REG_DIS_READING, {16'd0, dis});
        cnt_settings++;
    endtask

    function automatic acss_pkg::item_t mk(logic [1:0] cmd, logic [1:0] ch, logic en,
                                           logic [15:0] word, logic mv);
        acss_pkg::item_t it;
        it.cmd = cmd;
        it.channel = ch;
        it.enable = en;
        it.conv_word = word;
        it.in_millivolts = mv;
        return it;
    endfunction

    function automatic acss_pkg::item_t rand_item();
        acss_pkg::item_t it;
        int    pick;
        logic [15:0] word;
        pick = $urandom_range(99);
        word = 16'($urandom);
        case ($urandom_range(9))
            0: word = 16'h7FF0 | 16'($urandom_range(15));
            1: word = 16'h8000 | 16'($urandom_range(15));
            2: word = 16'hFFFF;
            3: word = 16'h0000;
            default: ;
        endcase
        it = mk(acss_pkg::CMD_CONV, 2'($urandom_range(3)), 1'($urandom_range(1)), word,
                1'($urandom_range(1)));
        if (pick < 40)
            it.cmd = acss_pkg::CMD_CONV;
        else if (pick < 67)
            it.cmd = acss_pkg::CMD_READ;
        else if (pick < 85)
        begin
            it.cmd = acss_pkg::CMD_CFG;
            it.enable = ($urandom_range(99) < 65);
        end
        else
            it.cmd = acss_pkg::CMD_WDOG;
        return it;
    endfunction

    function automatic logic [31:0] pick_fs();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'd8192;
            2: return 32'd16383;
            3: return 32'd1;
            default: return 32'($urandom_range(8192));
        endcase
    endfunction

    function automatic logic signed [15:0] pick_dis();
        case ($urandom_range(5))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            3: return -16'sd1;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        send_item(mk(acss_pkg::CMD_READ, 2'd0, 1'b0, 16'h0000, 1'b0));
        send_item(mk(acss_pkg::CMD_CONV, 2'd0, 1'b0, 16'h1230, 1'b0));
        send_item(mk(acss_pkg::CMD_WDOG, 2'd0, 1'b0, 16'h0000, 1'b0));
        send_item(mk(acss_pkg::CMD_CFG,  2'd1, 1'b1, 16'h0000, 1'b0));
        send_item(mk(acss_pkg::CMD_READ, 2'd1, 1'b0, 16'h0000, 1'b0));
        send_item(mk(acss_pkg::CMD_CONV, 2'd0, 1'b0, 16'h7FF0, 1'b0));
        send_item(mk(acss_pkg::CMD_READ, 2'd1, 1'b0, 16'h0000, 1'b0));
        send_item(mk(acss_pkg::CMD_READ, 2'd1, 1'b0, 16'h0000, 1'b1));
        send_item(mk(acss_pkg::CMD_CFG,  2'd2, 1'b1, 16'hFFFF, 1'b0));
        // reserved low bits set, most negative code
        send_item(mk(acss_pkg::CMD_CONV, 2'd3, 1'b1, 16'h800F, 1'b1));
        send_item(mk(acss_pkg::CMD_CONV, 2'd0, 1'b0, 16'hFFF0, 1'b0));
        send_item(mk(acss_pkg::CMD_READ, 2'd2, 1'b0, 16'h0000, 1'b1));
        send_item(mk(acss_pkg::CMD_READ, 2'd1, 1'b1, 16'hFFFF, 1'b1));
        // kicked tick, then an expired one forces a read
        send_item(mk(acss_pkg::CMD_WDOG, 2'd3, 1'b1, 16'h0000, 1'b0));
        send_item(mk(acss_pkg::CMD_WDOG, 2'd0, 1'b0, 16'h0000, 1'b0));
        send_item(mk(acss_pkg::CMD_READ, 2'd1, 1'b0, 16'h0000, 1'b0));
        // disable the current channel: next conversion only rotates
        send_item(mk(acss_pkg::CMD_CFG,  2'd1, 1'b0, 16'h0000, 1'b0));
        send_item(mk(acss_pkg::CMD_CONV, 2'd0, 1'b0, 16'h0010, 1'b0));
        send_item(mk(acss_pkg::CMD_CONV, 2'd0, 1'b0, 16'h0000, 1'b0));
        send_item(mk(acss_pkg::CMD_READ, 2'd3, 1'b0, 16'h0000, 1'b0));
        // last channel off stops the watchdog
        send_item(mk(acss_pkg::CMD_CFG,  2'd2, 1'b0, 16'h0000, 1'b1));
        send_item(mk(acss_pkg::CMD_WDOG, 2'd0, 1'b0, 16'h0000, 1'b0));
        send_item(mk(acss_pkg::CMD_CFG,  2'd1, 1'b1, 16'h0000, 1'b0));
        // disabled value scaled to mV saturates
        send_item(mk(acss_pkg::CMD_READ, 2'd1, 1'b0, 16'h0000, 1'b1));
        send_item(mk(acss_pkg::CMD_READ, 2'd1, 1'b0, 16'h0000, 1'b0));
    endtask

    task automatic test_register_settings();
        logic [31:0]       fs_list [5];
        logic signed [15:0] dis_list [5];
        fs_list = '{32'd0, 32'd8192, 32'd16383, 32'd1, 32'd4096};
        dis_list = '{16'sd32767, -16'sd32768, 16'sd0, -16'sd1, 16'sh1234};
        for (int s = 0; s < 5; s++)
        begin
            set_regs(fs_list[s], dis_list[s]);
            for (int c = 0; c < 4; c++)
                send_item(mk(acss_pkg::CMD_CFG, 2'(c), 1'b1, 16'h0000, 1'b0));
            repeat (6)
                send_item(mk(acss_pkg::CMD_CONV, 2'd0, 1'b0, 16'($urandom), 1'b0));
            for (int c = 0; c < 4; c++)
                send_item(mk(acss_pkg::CMD_READ, 2'(c), 1'b0, 16'h0000, 1'b1));
            send_item(mk(acss_pkg::CMD_CFG, 2'(s % 4), 1'b0, 16'h0000, 1'b0));
            send_item(mk(acss_pkg::CMD_CFG, 2'(s % 4), 1'b1, 16'h0000, 1'b0));
            send_item(mk(acss_pkg::CMD_READ, 2'(s % 4), 1'b0, 16'h0000, 1'b1));
            send_item(mk(acss_pkg::CMD_READ, 2'(s % 4), 1'b0, 16'h0000, 1'b0));
        end
    endtask

    task automatic test_backpressure();
        stall_left = 300;
        src_idle = 1'b0;
        repeat (40) send_item(rand_item());
        src_idle = 1'b1;
        wait_drained();
    endtask

    task automatic test_random_traffic();
        for (int n = 0; n < 1300; n++)
        begin
            if (n % 260 == 0)
                set_regs(pick_fs(), pick_dis());
            // full-rate stretch on both sides
            src_idle = !(n >= 520 && n < 820);
            sink_idle = src_idle;
            send_item(rand_item());
        end
        src_idle = 1'b1;
        sink_idle = 1'b1;
    endtask

    initial
    begin
        en_mask = '0;
        pend_mask = '0;
        cur_ch = '0;
        readings_ok = 1'b0;
        wd_kicked = 1'b0;
        wd_running = 1'b0;
        fs_mv = acss_pkg::FS_RESET;
        dis_val = acss_pkg::READING_RESET;
        for (int c = 0; c < 4; c++)
            chan_reading[c] = acss_pkg::READING_RESET;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_register_settings();
        test_backpressure();
        test_random_traffic();
        wait_drained();

        $display("Covered %0d transactions, %0d results checked, %0d register settings.",
                 cnt_items, cnt_results, cnt_settings);
        $display("Stored readings %0d, millivolt reads %0d, forced reads %0d.",
                 cnt_notify, cnt_mv, cnt_forced);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
